// ===== hw/rtl/dbba_pkg.sv =====
// Shared types and constants of the data block bitmap allocator.
package dbba_pkg;

  localparam int unsigned MaxBlocks  = 1024;
  localparam int unsigned WordBits   = 32;
  localparam int unsigned NumWords   = (MaxBlocks + WordBits - 1) / WordBits;
  localparam int unsigned BlockBytes = 512;

  localparam int unsigned BitIdxW  = $clog2(WordBits);
  localparam int unsigned WordIdxW = $clog2(NumWords);
  localparam int unsigned IndexW   = 10;
  localparam int unsigned CountW   = 11;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned BlockShW = $clog2(BlockBytes);
  localparam int unsigned KindW    = 2;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [KindW-1:0] {
    KindAlloc = 2'd0,
    KindSet   = 2'd1,
    KindClear = 2'd2,
    KindQuery = 2'd3
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    StatOk    = 2'd0,
    StatFull  = 2'd1,
    StatRange = 2'd2
  } status_e;

  localparam logic [CfgIdxW-1:0] CfgBlockCount = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDataBase   = 2'd1;

endpackage

// ===== hw/rtl/data_block_bitmap_allocator_top.sv =====
// Bitmap first-fit block allocator: 32-word used-flag RAM with read-modify-write control.
// A set, clear or query reads its own bitmap word; an allocate scans n bitmap words
// (1 to 32, one RAM read per cycle) until it finds a free block or reaches the last managed word.
// One request at a time: the next is taken once the result has moved to the output register,
// which waits while the previous result beat is stalled. Reset clears the config registers
// and the per-word valid flags, so every block reads as free; RAM contents are not cleared.
module data_block_bitmap_allocator_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [dbba_pkg::KindW-1:0]      in_kind_i,
  input  logic [dbba_pkg::IndexW-1:0]     in_block_index_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [dbba_pkg::StatusW-1:0]    out_status_o,
  output logic [dbba_pkg::IndexW-1:0]     out_result_index_o,
  output logic [dbba_pkg::AddrW-1:0]      out_block_address_o,
  output logic                            out_bit_value_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dbba_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [dbba_pkg::CfgDataW-1:0]   cfg_data_i
);
  import dbba_pkg::*;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StEval = 3'b010,
    StDone = 3'b100
  } state_e;

  state_e                state_q, state_d;
  logic [KindW-1:0]      kind_q, kind_d;
  logic [IndexW-1:0]     idx_q, idx_d;
  logic [CountW-1:0]     cnt_q, cnt_d;
  logic [WordIdxW-1:0]   word_q, word_d;
  logic [CountW-1:0]     block_count_q;
  logic [AddrW-1:0]      data_base_q;

  logic [WordBits-1:0]   mem [NumWords];
  logic [NumWords-1:0]   vld_q;
  logic [WordBits-1:0]   rdata_q;
  logic                  rvld_q;
  logic [WordIdxW-1:0]   rd_addr;
  logic                  wr_en;
  logic [WordBits-1:0]   wr_data;

  logic [StatusW-1:0]    res_status_q, res_status_d;
  logic [IndexW-1:0]     res_index_q, res_index_d;
  logic [AddrW-1:0]      res_addr_q, res_addr_d;
  logic                  res_bit_q, res_bit_d;

  logic                  out_valid_q, out_valid_d;
  logic [StatusW-1:0]    out_status_q;
  logic [IndexW-1:0]     out_index_q;
  logic [AddrW-1:0]      out_addr_q;
  logic                  out_bit_q;
  logic                  out_load;

  logic                  in_accept;
  logic [CountW-1:0]     eff_count;
  logic [WordBits-1:0]   word_v;
  logic [CountW-1:0]     rem;
  logic [WordBits-1:0]   lim;
  logic [WordBits-1:0]   free_bits;
  logic                  found;
  logic [BitIdxW-1:0]    first;
  logic                  last_word;
  logic                  in_range;
  logic [BitIdxW-1:0]    bit_sel;
  logic [WordBits-1:0]   one_hot;
  logic [IndexW-1:0]     addr_idx;
  logic [AddrW-1:0]      calc_addr;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != StIdle);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign eff_count   = block_count_q[CountW-1] ? CountW'(MaxBlocks) : block_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= '0;
      data_base_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgBlockCount: block_count_q <= cfg_data_i[CountW-1:0];
        CfgDataBase:   data_base_q   <= cfg_data_i[AddrW-1:0];
        default: ;
      endcase
    end
  end

  // Bitmap RAM
  always_comb begin
    if (state_q == StIdle) begin
      rd_addr = (in_kind_i == KindAlloc) ? '0 : in_block_index_i[IndexW-1 -: WordIdxW];
    end else begin
      rd_addr = word_q + WordIdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[word_q] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[rd_addr];
      if (wr_en) begin
        vld_q[word_q] <= 1'b1;
      end
    end
  end

  // Word evaluation
  assign word_v    = rvld_q ? rdata_q : '0;
  assign rem       = cnt_q - {1'b0, word_q, BitIdxW'(0)};
  assign lim       = (rem >= CountW'(WordBits)) ? '1
                   : ((WordBits'(1) << rem[BitIdxW-1:0]) - WordBits'(1));
  assign free_bits = ~word_v & lim;
  assign found     = |free_bits;
  assign last_word = (rem <= CountW'(WordBits));
  assign in_range  = ({1'b0, idx_q} < cnt_q);

  always_comb begin
    first = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        first = BitIdxW'(i);
      end
    end
  end

  assign bit_sel   = (kind_q == KindAlloc) ? first : idx_q[BitIdxW-1:0];
  assign one_hot   = WordBits'(1) << bit_sel;
  assign addr_idx  = (kind_q == KindAlloc) ? {word_q, first} : idx_q;
  assign calc_addr = data_base_q + AddrW'({addr_idx, BlockShW'(0)});

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    word_d       = word_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    res_addr_d   = res_addr_q;
    res_bit_d    = res_bit_q;
    wr_en        = 1'b0;
    wr_data      = word_v;
    out_load     = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          kind_d  = in_kind_i;
          idx_d   = in_block_index_i;
          cnt_d   = eff_count;
          word_d  = (in_kind_i == KindAlloc) ? '0 : in_block_index_i[IndexW-1 -: WordIdxW];
          state_d = StEval;
        end
      end
      StEval: begin
        if (kind_q == KindAlloc) begin
          if (found) begin
            wr_en        = 1'b1;
            wr_data      = word_v | one_hot;
            res_status_d = StatOk;
            res_index_d  = addr_idx;
            res_addr_d   = calc_addr;
            res_bit_d    = 1'b0;
            state_d      = StDone;
          end else if (last_word) begin
            res_status_d = StatFull;
            res_index_d  = '0;
            res_addr_d   = '0;
            res_bit_d    = 1'b0;
            state_d      = StDone;
          end else begin
            word_d = word_q + WordIdxW'(1);
          end
        end else begin
          res_index_d = idx_q;
          state_d     = StDone;
          if (in_range) begin
            res_status_d = StatOk;
            res_addr_d   = calc_addr;
            res_bit_d    = word_v[bit_sel];
            if (kind_q == KindSet) begin
              wr_en   = 1'b1;
              wr_data = word_v | one_hot;
            end else if (kind_q == KindClear) begin
              wr_en   = 1'b1;
              wr_data = word_v & ~one_hot;
            end
          end else begin
            res_status_d = StatRange;
            res_addr_d   = '0;
            res_bit_d    = 1'b0;
          end
        end
      end
      StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    idx_q        <= idx_d;
    cnt_q        <= cnt_d;
    word_q       <= word_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    res_addr_q   <= res_addr_d;
    res_bit_q    <= res_bit_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_index_q  <= res_index_q;
      out_addr_q   <= res_addr_q;
      out_bit_q    <= res_bit_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_status_o        = out_status_q;
  assign out_result_index_o  = out_index_q;
  assign out_block_address_o = out_addr_q;
  assign out_bit_value_o     = out_bit_q;

endmodule

// ===== hw/rtl/dbba_checker.sv =====
// Port-level checks for the bitmap allocator, bound to the top level.
module dbba_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [dbba_pkg::StatusW-1:0]    out_status_o,
  input logic [dbba_pkg::IndexW-1:0]     out_result_index_o,
  input logic [dbba_pkg::AddrW-1:0]      out_block_address_o,
  input logic                            out_bit_value_o
);
  import dbba_pkg::*;

  // one request at a time: busy right after a beat is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a request is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_status_o)
      && $stable(out_result_index_o) && $stable(out_block_address_o)
      && $stable(out_bit_value_o))
    else $error("stalled result beat changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_status_o == StatFull |->
      out_result_index_o == '0 && out_block_address_o == '0 && !out_bit_value_o)
    else $error("full result carries non-zero fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_status_o == StatRange |->
      out_block_address_o == '0 && !out_bit_value_o)
    else $error("out-of-range result carries address or flag");

endmodule

bind data_block_bitmap_allocator_top dbba_checker u_dbba_checker (.*);

// ===== verif/testbench.sv =====
// Self-checking testbench for the first-fit data block bitmap allocator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dbba_pkg::*;

  typedef struct {
    kind_e              kind;
    logic [IndexW-1:0]  idx;
    int unsigned        gap;
  } request_t;

  typedef struct {
    status_e            status;
    logic [IndexW-1:0]  idx;
    logic [AddrW-1:0]   addr;
    logic               used;
  } outcome_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [KindW-1:0]     in_kind_i = '0;
  logic [IndexW-1:0]    in_block_index_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [StatusW-1:0]   out_status_o;
  logic [IndexW-1:0]    out_result_index_o;
  logic [AddrW-1:0]     out_block_address_o;
  logic                 out_bit_value_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  data_block_bitmap_allocator_top dut (.*);

  // local copy of the allocator state
  logic [WordBits-1:0]  used_map [NumWords];
  logic [CountW-1:0]    blk_count = '0;
  logic [AddrW-1:0]     base_addr = '0;

  request_t     pending_requests [$];
  outcome_t     awaited_results [$];
  int unsigned  gap_done = 0;
  int unsigned  stall_left = 0;
  int unsigned  rx_beats = 0;
  bit           rx_calm = 1'b0;
  bit           tx_calm = 1'b0;
  int unsigned  fails = 0;
  int unsigned  n_requests = 0, n_allocs = 0, n_full = 0, n_range = 0, n_settings = 1;

  initial forever #10 clk_i = ~clk_i;

  function automatic int unsigned managed_blocks();
    return (blk_count > MaxBlocks) ? MaxBlocks : int'(blk_count);
  endfunction

  function automatic void apply_request(kind_e kind, logic [IndexW-1:0] idx);
    int unsigned cnt;
    outcome_t    res;
    cnt = managed_blocks();
    res = '{StatOk, '0, '0, 1'b0};
    n_requests++;
    if (kind == KindAlloc) begin
      res.status = StatFull;
      for (int i = 0; i < cnt; i++) begin
        if (!used_map[i / WordBits][i % WordBits]) begin
          used_map[i / WordBits][i % WordBits] = 1'b1;
          res.status = StatOk;
          res.idx = IndexW'(i);
          res.addr = base_addr + AddrW'(i) * BlockBytes;
          break;
        end
      end
      if (res.status == StatFull) n_full++;
      else n_allocs++;
    end else begin
      res.idx = idx;
      if (idx >= cnt) begin
        res.status = StatRange;
        n_range++;
      end else begin
        res.used = used_map[idx / WordBits][idx % WordBits];
        res.addr = base_addr + AddrW'(idx) * BlockBytes;
        if (kind == KindSet) used_map[idx / WordBits][idx % WordBits] = 1'b1;
        else if (kind == KindClear) used_map[idx / WordBits][idx % WordBits] = 1'b0;
      end
    end
    awaited_results.push_back(res);
  endfunction

  function automatic void note_fail(string msg);
    fails++;
    if (fails <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    logic free;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_done <= 0;
      foreach (used_map[w]) used_map[w] = '0;
    end else begin
      free = !in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        apply_request(kind_e'(in_kind_i), in_block_index_i);
        free = 1'b1;
      end
      if (free && pending_requests.size() != 0 && gap_done >= pending_requests[0].gap) begin
        in_valid_i <= 1'b1;
        in_kind_i <= pending_requests[0].kind;
        in_block_index_i <= pending_requests[0].idx;
        void'(pending_requests.pop_front());
        gap_done <= 0;
      end else if (free) begin
        in_valid_i <= 1'b0;
        if (pending_requests.size() != 0) gap_done <= gap_done + 1;
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned hold;
    outcome_t    want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else begin
      hold = (stall_left != 0) ? stall_left - 1 : 0;
      if (out_valid_o && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          note_fail($sformatf("result beat with nothing outstanding, index %0d",
                              out_result_index_o));
        end else begin
          want = awaited_results.pop_front();
          if (out_status_o != want.status || out_result_index_o != want.idx ||
              out_block_address_o != want.addr || out_bit_value_o != want.used)
            note_fail($sformatf(
              "exp st=%0d idx=%0d addr=%h bit=%0d, got st=%0d idx=%0d addr=%h bit=%0d",
              want.status, want.idx, want.addr, want.used, out_status_o,
              out_result_index_o, out_block_address_o, out_bit_value_o));
        end
        rx_beats++;
        if (rx_beats % 24 == 0) rx_calm = ($urandom_range(0, 2) == 0);
        hold = rx_calm ? 0 : $urandom_range(0, 13);
      end
      stall_left <= hold;
      out_stall_i <= (hold != 0);
    end
  end

  task automatic queue_request(kind_e kind, logic [IndexW-1:0] idx);
    pending_requests.push_back('{kind, idx, tx_calm ? 0 : $urandom_range(0, 13)});
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_valid_i || awaited_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CfgBlockCount) begin
      blk_count = val[CountW-1:0];
      n_settings++;
    end else if (idx == CfgDataBase) begin
      base_addr = val;
    end
    @(posedge clk_i);
  endtask

  task automatic random_phase(logic [CountW-1:0] count, logic [AddrW-1:0] base, int n);
    int unsigned cnt, r;
    kind_e       kind;
    write_reg(CfgBlockCount, CfgDataW'(count));
    write_reg(CfgDataBase, base);
    cnt = managed_blocks();
    for (int i = 0; i < n; i++) begin
      if (i % 16 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      kind = (r < 4) ? KindAlloc : (r < 6) ? KindSet : (r < 8) ? KindClear : KindQuery;
      if (cnt != 0 && $urandom_range(0, 3) != 0)
        queue_request(kind, IndexW'($urandom_range(0, cnt - 1)));
      else
        queue_request(kind, IndexW'($urandom_range(0, 1023)));
    end
    wait_idle();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: no managed blocks
    queue_request(KindAlloc, 10'd0);
    queue_request(KindSet, 10'd0);
    queue_request(KindQuery, 10'h3FF);
    wait_idle();

    // saturated count, base address wrapping past the top
    write_reg(CfgBlockCount, CfgDataW'(11'h7FF));
    write_reg(CfgDataBase, 32'hFFFF_FE00);
    queue_request(KindAlloc, 10'h3FF);
    queue_request(KindAlloc, 10'd0);
    queue_request(KindSet, 10'h3FF);
    queue_request(KindQuery, 10'h3FF);
    queue_request(KindClear, 10'h3FF);
    queue_request(KindQuery, 10'h3FF);
    queue_request(KindClear, 10'd1);
    queue_request(KindAlloc, 10'd0);
    queue_request(KindSet, 10'd0);
    queue_request(KindClear, 10'd2);
    queue_request(KindQuery, 10'd1);
    queue_request(KindSet, 10'h2AA);
    queue_request(KindQuery, 10'h155);
    wait_idle();

    // two blocks, both taken: full, then out of range
    write_reg(CfgBlockCount, CfgDataW'(11'd2));
    write_reg(2'd2, 32'hDEAD_BEEF);
    write_reg(2'd3, 32'h1234_5678);
    queue_request(KindAlloc, 10'd0);
    queue_request(KindQuery, 10'd2);
    queue_request(KindSet, 10'd1);
    queue_request(KindClear, 10'h3FF);
    queue_request(KindQuery, 10'd1);
    wait_idle();

    random_phase(11'd1024, 32'h0000_0000, 55);
    random_phase(11'd33, $urandom, 55);
    random_phase(11'd1, $urandom, 55);
    random_phase(11'd0, $urandom, 55);
    random_phase(11'h7FF, 32'hFFFF_FFFF, 55);
    random_phase(CountW'($urandom_range(0, 2047)), $urandom, 55);
    random_phase(11'd64, $urandom, 55);
    random_phase(CountW'($urandom_range(1, 1024)), $urandom, 55);

    repeat (40) @(posedge clk_i);
    if (awaited_results.size() != 0)
      note_fail($sformatf("%0d results never arrived", awaited_results.size()));
    $display("Ran %0d requests over %0d block count settings: %0d allocations granted,",
             n_requests, n_settings, n_allocs);
    $display("%0d allocations refused as full, %0d indexed requests out of range.",
             n_full, n_range);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
